FILE: sv/mspc_pkg.sv
// ----------------------------------------------------------------------------
// mspc_pkg
// Shared types, register indexes and arithmetic helpers of the speed PI loop.
// ----------------------------------------------------------------------------
`default_nettype none

package mspc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned MulAW    = 34;
  localparam int unsigned MulBW    = 25;
  localparam int unsigned ProdW    = MulAW + MulBW;   // 59
  localparam int unsigned RndW     = ProdW - 16;      // 43
  localparam int unsigned SumW     = 43;

  localparam logic [16:0] OneQ16      = 17'd65536;
  localparam logic [30:0] CmdNegFloor = 31'd655;      // 0.01 in Q15.16

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_INTEG_GAIN   = 3'd0,
    REG_REF_WEIGHT   = 3'd1,
    REG_OUT_GAIN     = 3'd2,
    REG_INTEG_LIMIT  = 3'd3,
    REG_CURRENT_MAX  = 3'd4,
    REG_BLEND_WEIGHT = 3'd5,
    REG_FF_GAIN      = 3'd6,
    REG_FF_ENABLE    = 3'd7
  } cfg_idx_e;

  // Operand select of the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE  = 3'd0,
    MUL_BLEND = 3'd1,
    MUL_INTEG = 3'd2,
    MUL_REF   = 3'd3,
    MUL_FF    = 3'd4,
    MUL_OHI   = 3'd5,
    MUL_OLO   = 3'd6
  } mul_sel_e;

  typedef struct packed {
    logic [23:0] integ_gain;
    logic [23:0] ref_weight;
    logic [23:0] out_gain;
    logic [30:0] integ_limit;
    logic [30:0] current_max;
    logic [16:0] blend_weight;
    logic [23:0] ff_gain;
    logic        ff_enable;
  } cfg_t;

  // Controller to datapath command group
  typedef struct packed {
    logic     capture;
    mul_sel_e mul_sel;
    logic     blend_ld;
    logic     acc_ld;
    logic     ref_add;
    logic     ff_add;
    logic     res_ld;
    logic     out_load;
  } dp_cmd_t;

  // Round to nearest, ties toward +inf, of p / 2^16
  function automatic logic signed [RndW-1:0] rnd16(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] t;
    t = p + ProdW'(32768);
    return t[ProdW-1:16];
  endfunction

endpackage

`default_nettype wire

FILE: sv/mspc_regs.sv
// ----------------------------------------------------------------------------
// mspc_regs
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mspc_regs
  import mspc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output      cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_INTEG_GAIN:   cfg_d.integ_gain   = cfg_data_i[23:0];
        REG_REF_WEIGHT:   cfg_d.ref_weight   = cfg_data_i[23:0];
        REG_OUT_GAIN:     cfg_d.out_gain     = cfg_data_i[23:0];
        REG_INTEG_LIMIT:  cfg_d.integ_limit  = cfg_data_i[30:0];
        REG_CURRENT_MAX:  cfg_d.current_max  = cfg_data_i[30:0];
        REG_BLEND_WEIGHT: cfg_d.blend_weight = cfg_data_i[16:0];
        REG_FF_GAIN:      cfg_d.ff_gain      = cfg_data_i[23:0];
        REG_FF_ENABLE:    cfg_d.ff_enable    = cfg_data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: sv/mspc_dp.sv
// ----------------------------------------------------------------------------
// mspc_dp
// Datapath: operand registers, one shared signed multiplier, integrator,
// loop sum and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mspc_dp
  import mspc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire dp_cmd_t            cmd_i,
  input  wire logic signed [31:0] speed_ref_i,
  input  wire logic signed [31:0] speed_filtered_i,
  input  wire logic signed [31:0] speed_observer_i,
  input  wire logic signed [31:0] speed_ff_i,
  output      logic [30:0]        current_cmd_o,
  output      logic signed [31:0] speed_blended_o
);

  logic signed [31:0]      ref_q, filt_q, obs_q, ff_q;
  logic signed [31:0]      blend_q, blend_d;
  logic signed [31:0]      integ_q, integ_d;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic [50:0]             res_hi_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic [30:0]             out_cmd_q, out_cmd_d;
  logic signed [31:0]      out_blend_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [RndW-1:0]  rnd_v;
  logic [16:0]             w_sat;
  logic signed [32:0]      diff, err;
  logic signed [43:0]      acc_w, acc_c, lim_p, lim_n;
  logic [51:0]             res_w, res_c;

  assign w_sat = (cfg_i.blend_weight > OneQ16) ? OneQ16 : cfg_i.blend_weight;
  assign diff  = {obs_q[31], obs_q} - {filt_q[31], filt_q};
  assign err   = {ref_q[31], ref_q} - {blend_q[31], blend_q};
  assign rnd_v = rnd16(prod_q);

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_BLEND: begin
        mul_a = {diff[32], diff};
        mul_b = {8'b0, w_sat};
      end
      MUL_INTEG: begin
        mul_a = {err[32], err};
        mul_b = {1'b0, cfg_i.integ_gain};
      end
      MUL_REF: begin
        mul_a = {{2{ref_q[31]}}, ref_q};
        mul_b = {1'b0, cfg_i.ref_weight};
      end
      MUL_FF: begin
        mul_a = {{2{ff_q[31]}}, ff_q};
        mul_b = {1'b0, cfg_i.ff_gain};
      end
      MUL_OHI: begin
        mul_a = {7'b0, sum_q[SumW-1:16]};
        mul_b = {1'b0, cfg_i.out_gain};
      end
      MUL_OLO: begin
        mul_a = {18'b0, sum_q[15:0]};
        mul_b = {1'b0, cfg_i.out_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Blend: filt + round((obs - filt) * w / 2^16); always fits 32 bits
  assign blend_d = filt_q + rnd_v[31:0];

  // Integrator update with symmetric clamp
  assign lim_p = {13'b0, cfg_i.integ_limit};
  assign lim_n = -lim_p;
  assign acc_w = {{12{integ_q[31]}}, integ_q} + {rnd_v[RndW-1], rnd_v};

  always_comb begin
    if (acc_w > lim_p) begin
      acc_c = lim_p;
    end else if (acc_w < lim_n) begin
      acc_c = lim_n;
    end else begin
      acc_c = acc_w;
    end
  end

  assign integ_d = acc_c[31:0];

  always_comb begin
    sum_d = sum_q;
    if (cmd_i.acc_ld) begin
      sum_d = acc_c[SumW-1:0] - {{(SumW-32){blend_q[31]}}, blend_q};
    end else if (cmd_i.ref_add || (cmd_i.ff_add && cfg_i.ff_enable)) begin
      sum_d = sum_q + rnd_v;
    end
  end

  // Output scaling: hi part * gain + round(lo part * gain / 2^16)
  assign res_w = {1'b0, res_hi_q} + {27'b0, rnd_v[24:0]};
  assign res_c = (res_w > {21'b0, cfg_i.current_max}) ? {21'b0, cfg_i.current_max} : res_w;

  always_comb begin
    if (cfg_i.out_gain == '0 || sum_q == '0) begin
      out_cmd_d = '0;
    end else if (sum_q[SumW-1]) begin
      out_cmd_d = CmdNegFloor;
    end else begin
      out_cmd_d = res_c[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (cmd_i.acc_ld) begin
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ref_q  <= speed_ref_i;
      filt_q <= speed_filtered_i;
      obs_q  <= speed_observer_i;
      ff_q   <= speed_ff_i;
    end
    prod_q <= prod_d;
    sum_q  <= sum_d;
    if (cmd_i.blend_ld) begin
      blend_q <= blend_d;
    end
    if (cmd_i.res_ld) begin
      res_hi_q <= prod_q[50:0];
    end
    if (cmd_i.out_load) begin
      out_cmd_q   <= out_cmd_d;
      out_blend_q <= blend_q;
    end
  end

  assign current_cmd_o   = out_cmd_q;
  assign speed_blended_o = out_blend_q;

endmodule

`default_nettype wire

FILE: sv/mspc_ctrl.sv
// ----------------------------------------------------------------------------
// mspc_ctrl
// Sequencer: steps one transaction through the shared multiplier and owns
// the input stall and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module mspc_ctrl
  import mspc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_stall_o,
  output      logic out_valid_o,
  input  wire logic out_stall_i,
  output      dp_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_MBL  = 10'b00_0000_0010,
    S_BLD  = 10'b00_0000_0100,
    S_MIG  = 10'b00_0000_1000,
    S_ACC  = 10'b00_0001_0000,
    S_RWA  = 10'b00_0010_0000,
    S_FFA  = 10'b00_0100_0000,
    S_MHI  = 10'b00_1000_0000,
    S_MLO  = 10'b01_0000_0000,
    S_FIN  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, load;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign load       = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_NONE;
    state_d       = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.capture = accept;
        if (accept) begin
          state_d = S_MBL;
        end
      end
      S_MBL: begin
        cmd_o.mul_sel = MUL_BLEND;
        state_d       = S_BLD;
      end
      S_BLD: begin
        cmd_o.blend_ld = 1'b1;
        state_d        = S_MIG;
      end
      S_MIG: begin
        cmd_o.mul_sel = MUL_INTEG;
        state_d       = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_ld  = 1'b1;
        cmd_o.mul_sel = MUL_REF;
        state_d       = S_RWA;
      end
      S_RWA: begin
        cmd_o.ref_add = 1'b1;
        cmd_o.mul_sel = MUL_FF;
        state_d       = S_FFA;
      end
      S_FFA: begin
        cmd_o.ff_add = 1'b1;
        state_d      = S_MHI;
      end
      S_MHI: begin
        cmd_o.mul_sel = MUL_OHI;
        state_d       = S_MLO;
      end
      S_MLO: begin
        cmd_o.res_ld  = 1'b1;
        cmd_o.mul_sel = MUL_OLO;
        state_d       = S_FIN;
      end
      S_FIN: begin
        // keep the low product in place while the result waits
        cmd_o.mul_sel  = MUL_OLO;
        cmd_o.out_load = load;
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // An accepted transaction always starts with the blend multiply
  a_accept_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_MBL)
    else $error("accepted transaction did not start the sequence");

  // A new result only appears from the final step
  a_valid_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_FIN)
    else $error("output valid rose outside the final step");

  // A blocked output register holds the finished transaction in the final step
  a_fin_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && out_valid_q && out_stall_i |=> state_q == S_FIN)
    else $error("result overwritten while output stalled");

endmodule

`default_nettype wire

FILE: sv/motor_speed_pi_controller.sv
// ----------------------------------------------------------------------------
// motor_speed_pi_controller
// Speed loop PI controller with clamped integrator and current command clamp.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o) takes one transaction per control
//    period: speed reference, filtered speed, observer speed, feedforward.
//  - Output channel (out_valid_o / out_stall_i) returns the q-axis current
//    command and the blended speed, one result per input transaction.
//  - Config channel (cfg_valid_i / cfg_ready_o) writes one register per
//    transaction; always ready. Write only while the loop is idle.
//  - Timing: the sequencer steps six products through one 34x25 multiplier,
//    then loads the result into the output register; a new transaction is
//    taken only once the last one has left the sequencer.
//  - The input stalls while a transaction is in flight. A finished result
//    waits in the output register; when the receiver stalls, the next
//    transaction is still taken and computed, and held in its last step
//    until the output register frees up.
//  - Reset clears the integrator, all configuration registers and the
//    output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_speed_pi_controller
  import mspc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input transaction
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic signed [31:0]  speed_ref_i,
  input  wire logic signed [31:0]  speed_filtered_i,
  input  wire logic signed [31:0]  speed_observer_i,
  input  wire logic signed [31:0]  speed_ff_i,
  // result transaction
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [30:0]         current_cmd_o,
  output      logic signed [31:0]  speed_blended_o,
  // configuration writes
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  // register file
  mspc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // sequencer: blend, integrate, reference, feedforward, output scaling
  mspc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  mspc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .speed_ref_i      (speed_ref_i),
    .speed_filtered_i (speed_filtered_i),
    .speed_observer_i (speed_observer_i),
    .speed_ff_i       (speed_ff_i),
    .current_cmd_o    (current_cmd_o),
    .speed_blended_o  (speed_blended_o)
  );

endmodule

`default_nettype wire

FILE: dv/motor_speed_pi_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_speed_pi_controller_tb
// Self-checking bench for the speed PI loop: a bit-exact current command
// predictor runs beside the block, fed by directed corners, a backpressure
// burst and three randomized phases with varying idle patterns.
// ----------------------------------------------------------------------------

module motor_speed_pi_controller_tb
  import mspc_pkg::*;
();

  localparam int unsigned CycleLimit  = 500_000; // generous run bound
  localparam int unsigned SettleCyc   = 16;      // longer than the result latency
  localparam int unsigned ChunkItems  = 50;      // random items per config
  localparam int unsigned PrintCap    = 200;
  localparam int          OneQ        = 65536;   // 1.0 in Q15.16 / Q8.16
  localparam longint      Int32Max    = 64'sd2147483647;
  localparam longint      Int32Min    = -64'sd2147483648;

  // one result transaction, as predicted
  typedef struct packed {
    logic [30:0]        current_cmd;
    logic signed [31:0] speed_blended;
  } loop_result_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input known from time zero
  // --------------------------------------------------------------------------
  logic                clk_i;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_stall_o;
  logic signed [31:0]  speed_ref_i      = '0;
  logic signed [31:0]  speed_filtered_i = '0;
  logic signed [31:0]  speed_observer_i = '0;
  logic signed [31:0]  speed_ff_i       = '0;
  logic                out_valid_o;
  logic                out_stall_i      = 1'b0;
  logic [30:0]         current_cmd_o;
  logic signed [31:0]  speed_blended_o;
  logic                cfg_valid_i      = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i      = '0;
  logic [CfgDataW-1:0] cfg_data_i       = '0;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  cfg_t               loop_cfg    = '0;  // shadow of the register file
  logic signed [31:0] integ_state = '0;  // shadow of the integrator
  loop_result_t       pending_cmds[$];   // predicted results, oldest first
  int unsigned        mismatch_count = 0;
  int unsigned        cycle_count    = 0;
  int unsigned        send_idle_pct  = 0; // sender idle chance per item
  int unsigned        recv_idle_pct  = 0; // receiver stall chance per cycle
  int unsigned        hold_left      = 0; // forced receiver stall, in cycles

  motor_speed_pi_controller dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .speed_ref_i      (speed_ref_i),
    .speed_filtered_i (speed_filtered_i),
    .speed_observer_i (speed_observer_i),
    .speed_ff_i       (speed_ff_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .current_cmd_o    (current_cmd_o),
    .speed_blended_o  (speed_blended_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // x / 2^16 rounded to nearest, ties toward +inf (arithmetic shift = floor)
  function automatic longint round_q16(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  // Expected result of one input transaction; advances the integrator shadow.
  function automatic loop_result_t predict_current_cmd(logic signed [31:0] spd_ref,
                                                       logic signed [31:0] spd_filt,
                                                       logic signed [31:0] spd_obs,
                                                       logic signed [31:0] spd_ff);
    loop_result_t res;
    longint       w, blend, err, acc, lim, total, mag, scaled;
    // observer weight saturates at one
    w = (loop_cfg.blend_weight > OneQ16) ? longint'(OneQ16)
                                          : longint'(loop_cfg.blend_weight);
    blend = round_q16(longint'(spd_filt) * (longint'(OneQ16) - w)
                      + longint'(spd_obs) * w);
    if (blend > Int32Max) blend = Int32Max;
    if (blend < Int32Min) blend = Int32Min;

    // integrator: full-width add, then symmetric clamp
    err = longint'(spd_ref) - blend;
    acc = longint'(integ_state) + round_q16(longint'(loop_cfg.integ_gain) * err);
    lim = longint'(loop_cfg.integ_limit);
    if (acc > lim)  acc = lim;
    if (acc < -lim) acc = -lim;
    integ_state = acc[31:0];

    total = acc + round_q16(longint'(loop_cfg.ref_weight) * longint'(spd_ref)) - blend;
    if (loop_cfg.ff_enable)
      total += round_q16(longint'(loop_cfg.ff_gain) * longint'(spd_ff));

    // sign of the loop sum decides; negative maps to the 0.01 floor even
    // when that is above current_max
    if (loop_cfg.out_gain == '0 || total == 0) begin
      res.current_cmd = '0;
    end else if (total < 0) begin
      res.current_cmd = CmdNegFloor;
    end else begin
      mag    = total;
      scaled = (mag >>> 16) * longint'(loop_cfg.out_gain)
             + ((longint'(mag[15:0]) * longint'(loop_cfg.out_gain) + 64'sd32768) >>> 16);
      if (scaled > longint'(loop_cfg.current_max)) scaled = longint'(loop_cfg.current_max);
      res.current_cmd = scaled[30:0];
    end
    res.speed_blended = blend[31:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: checks each accepted result, then picks the next stall
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PrintCap) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin : result_monitor
    loop_result_t want;
    // values seen here are the pre-edge ones: all drivers use NBAs
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_cmds.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: cmd=%0d blend=%0d",
                                current_cmd_o, speed_blended_o));
      end else begin
        want = pending_cmds.pop_front();
        if (current_cmd_o !== want.current_cmd)
          flag_mismatch($sformatf("current_cmd got %0d want %0d",
                                  current_cmd_o, want.current_cmd));
        if (speed_blended_o !== want.speed_blended)
          flag_mismatch($sformatf("speed_blended got %0d want %0d",
                                  speed_blended_o, want.speed_blended));
      end
    end
    // long hold-off first, random stalls otherwise
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Config side
  // --------------------------------------------------------------------------

  // Leaves cfg_valid_i high so back-to-back writes need one NBA per step.
  task automatic cfg_write(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_INTEG_GAIN:   loop_cfg.integ_gain   = data[23:0];
      REG_REF_WEIGHT:   loop_cfg.ref_weight   = data[23:0];
      REG_OUT_GAIN:     loop_cfg.out_gain     = data[23:0];
      REG_INTEG_LIMIT:  loop_cfg.integ_limit  = data[30:0];
      REG_CURRENT_MAX:  loop_cfg.current_max  = data[30:0];
      REG_BLEND_WEIGHT: loop_cfg.blend_weight = data[16:0];
      REG_FF_GAIN:      loop_cfg.ff_gain      = data[23:0];
      REG_FF_ENABLE:    loop_cfg.ff_enable    = data[0];
      default: ;
    endcase
  endtask

  // Full register file update; only called with the loop idle.
  task automatic set_config(logic [31:0] integ_gain, logic [31:0] ref_weight,
                            logic [31:0] out_gain, logic [31:0] integ_limit,
                            logic [31:0] current_max, logic [31:0] blend_weight,
                            logic [31:0] ff_gain, logic [31:0] ff_enable);
    cfg_write(REG_INTEG_GAIN,   integ_gain);
    cfg_write(REG_REF_WEIGHT,   ref_weight);
    cfg_write(REG_OUT_GAIN,     out_gain);
    cfg_write(REG_INTEG_LIMIT,  integ_limit);
    cfg_write(REG_CURRENT_MAX,  current_max);
    cfg_write(REG_BLEND_WEIGHT, blend_weight);
    cfg_write(REG_FF_GAIN,      ff_gain);
    cfg_write(REG_FF_ENABLE,    ff_enable);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'h00FF_FFFF;
      2:       return $urandom & 32'h00FF_FFFF;
      default: return $urandom_range(0, 3 * OneQ);
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom & 32'h7FFF_FFFF;
      default: return $urandom_range(0, 2000 * OneQ);
    endcase
  endfunction

  function automatic logic [31:0] pick_blend();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return OneQ;
      2:       return $urandom_range(OneQ + 1, 131071); // above one
      default: return $urandom_range(0, OneQ);
    endcase
  endfunction

  task automatic randomize_config();
    set_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(),
               pick_blend(), pick_gain(), $urandom_range(1));
  endtask

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offers one transaction and returns at the edge that accepts it, with
  // valid still high: the caller either sends again or drains in that step.
  task automatic send_speeds(logic signed [31:0] spd_ref, logic signed [31:0] spd_filt,
                             logic signed [31:0] spd_obs, logic signed [31:0] spd_ff);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    speed_ref_i      <= spd_ref;
    speed_filtered_i <= spd_filt;
    speed_observer_i <= spd_obs;
    speed_ff_i       <= spd_ff;
    do @(posedge clk_i); while (in_stall_o);
    pending_cmds.push_back(predict_current_cmd(spd_ref, spd_filt, spd_obs, spd_ff));
  endtask

  // Mostly a plausible operating point (speeds close together), sometimes
  // raw 32-bit noise per field.
  task automatic send_random_speeds();
    logic signed [31:0] r, f, o, d;
    r = int'($urandom_range(0, 6000 * OneQ)) - 3000 * OneQ;
    f = r + int'($urandom_range(0, 100 * OneQ)) - 50 * OneQ;
    o = f + int'($urandom_range(0, 20 * OneQ)) - 10 * OneQ;
    d = int'($urandom_range(0, 6000 * OneQ)) - 3000 * OneQ;
    if ($urandom_range(7) == 0) r = $urandom;
    if ($urandom_range(7) == 0) f = $urandom;
    if ($urandom_range(7) == 0) o = $urandom;
    if ($urandom_range(7) == 0) d = $urandom;
    send_speeds(r, f, o, d);
  endtask

  // Stop offering, wait for every pending result, then let the pipe settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Registers at reset value: zero gain, zero limit, blend = filtered speed.
  task automatic test_reset_state();
    send_speeds(32'sd1, 32'sd2, 32'sd3, 32'sd4);
    send_speeds(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_speeds(-32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1);
    wait_drained();
  endtask

  // Field extremes and bit patterns under a nominal tuning.
  task automatic test_field_extremes();
    set_config(OneQ / 2, OneQ, 2 * OneQ, 100 * OneQ, 500 * OneQ, OneQ / 4, OneQ / 2, 1);
    send_speeds(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_speeds(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_speeds(32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_speeds(-32'sd1, -32'sd1, -32'sd1, -32'sd1);
    send_speeds(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_speeds(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);
    wait_drained();
  endtask

  // Integrator pinned at +limit, then driven across to -limit; blend of
  // exactly one follows the observer.
  task automatic test_integrator_clamp();
    set_config(8 * OneQ, 0, OneQ, 10 * OneQ, 32'h7FFF_FFFF, OneQ, 0, 0);
    repeat (2) send_speeds(5 * OneQ, 0, 0, 0);
    repeat (3) send_speeds(-5 * OneQ, 0, 0, 0);
    wait_drained();
  endtask

  // Negative sum gives the 0.01 floor above a tiny current_max; positive
  // sum clamps to it; zero sum gives zero.
  task automatic test_negative_floor();
    set_config(0, 0, OneQ, 0, 100, 0, OneQ, 0);
    send_speeds(0, 20 * OneQ, 0, 7 * OneQ);
    send_speeds(0, -20 * OneQ, 0, 7 * OneQ);
    send_speeds(0, 0, 0, 0);
    wait_drained();
  endtask

  // Output gain zero forces a zero command whatever the sum.
  task automatic test_zero_out_gain();
    set_config(OneQ, OneQ, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, OneQ / 2, 2 * OneQ, 1);
    send_speeds(1000 * OneQ, -500 * OneQ, 200 * OneQ, 300 * OneQ);
    send_speeds(-1000 * OneQ, 500 * OneQ, -200 * OneQ, -300 * OneQ);
    wait_drained();
  endtask

  // All-ones writes: every register at its max, blend weight above one,
  // upper data bits dropped.
  task automatic test_all_ones_config();
    set_config('1, '1, '1, '1, '1, '1, '1, '1);
    send_speeds(10 * OneQ, 5 * OneQ, -3 * OneQ, OneQ);
    send_speeds(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_speeds(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
    wait_drained();
  endtask

  // Receiver holds off long enough that the output register and the held
  // last step fill up and the input stalls, while the sender keeps offering.
  task automatic test_output_backpressure();
    randomize_config();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 300;
    repeat (12) send_random_speeds();
    wait_drained();
  endtask

  // Random traffic in chunks, each under a fresh config; the sender now and
  // then pauses until every result is back.
  task automatic test_random_phase(int unsigned sender_pct, int unsigned receiver_pct,
                                   int unsigned n_items);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % ChunkItems == 0) begin
        wait_drained();
        randomize_config();
      end else if ($urandom_range(59) == 0) begin
        wait_drained();
      end
      send_random_speeds();
    end
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_field_extremes();
    test_integrator_clamp();
    test_negative_floor();
    test_zero_out_gain();
    test_all_ones_config();
    test_output_backpressure();
    test_random_phase(38, 65, 250);
    test_random_phase(65, 38, 250);
    test_random_phase(0, 0, 250);

    // every test ends drained, so nothing can be left pending here
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
